// ===== hw/rtl/psc_pkg.sv =====
package psc_pkg;

    typedef logic [63:0] t_word;

    // Configuration register indexes.
    localparam int unsigned CfgIdxW = 4;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P1    = 4'd0;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P2    = 4'd1;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P3    = 4'd2;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P4    = 4'd3;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P5    = 4'd4;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P6    = 4'd5;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P7    = 4'd6;
    localparam logic [CfgIdxW-1:0] CFG_CAL_P8_P9 = 4'd7;

    // Divider iterations, one quotient bit each.
    localparam int unsigned DivStages = 64;
    // Register stages from input to output register.
    localparam int unsigned Latency = 83;

    localparam logic signed [21:0] TEMP_OFFSET = 22'sd128000;
    localparam t_word OFFSET_TERM  = 64'h0000_8000_0000_0000;
    localparam t_word FULL_SCALE   = 64'd1048576;
    localparam logic signed [16:0] SCALE_3125 = 17'sd3125;

    // Signed division by 2^k that truncates toward zero.
    function automatic t_word f_sdiv_pow2(input t_word v, input int unsigned k);
        t_word bias;
        t_word sum;
        bias = v[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
        sum  = v + bias;
        return $unsigned($signed(sum) >>> k);
    endfunction

endpackage

// ===== hw/rtl/psc_mul64.sv =====
// Product modulo 2^64 of a 64-bit word and a 17-bit signed factor, two stages.
module psc_mul64 (
    input  logic                i_clk,
    input  logic                i_en,
    input  psc_pkg::t_word      i_x,
    input  logic signed [16:0]  i_y,
    output psc_pkg::t_word      o_p
);
    logic signed [32:0] w_lo;
    logic signed [31:0] w_hi;
    logic signed [49:0] n_lo;
    logic signed [48:0] n_hi;
    logic signed [49:0] r_lo;
    logic [31:0]        r_hi;
    psc_pkg::t_word     r_p;

    assign w_lo = $signed({1'b0, i_x[31:0]});
    assign w_hi = $signed(i_x[63:32]);
    assign n_lo = w_lo * i_y;
    assign n_hi = w_hi * i_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi[31:0];
            r_p  <= {{14{r_lo[49]}}, r_lo} + {r_hi, 32'd0};
        end
    end

    assign o_p = r_p;
endmodule

// ===== hw/rtl/psc_sq64.sv =====
// Square modulo 2^64 of a 64-bit word, two stages.
module psc_sq64 (
    input  logic           i_clk,
    input  logic           i_en,
    input  psc_pkg::t_word i_x,
    output psc_pkg::t_word o_p
);
    logic [63:0]    n_ll;
    logic [63:0]    n_hl;
    logic [63:0]    r_ll;
    logic [30:0]    r_hl;
    psc_pkg::t_word r_p;

    assign n_ll = i_x[31:0] * i_x[31:0];
    assign n_hl = i_x[63:32] * i_x[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_hl <= n_hl[30:0];
            // The cross term appears twice, hence the shift by 33.
            r_p  <= r_ll + {r_hl, 33'd0};
        end
    end

    assign o_p = r_p;
endmodule

// ===== hw/rtl/psc_div.sv =====
// Pipelined signed 64-bit division truncating toward zero.
// One stage takes magnitudes, one stage per quotient bit, one stage applies sign.
module psc_div (
    input  logic           i_clk,
    input  logic           i_en,
    input  psc_pkg::t_word i_num,
    input  psc_pkg::t_word i_den,
    output psc_pkg::t_word o_quo,
    output logic           o_zero
);
    localparam int unsigned N = psc_pkg::DivStages;

    logic [63:0]    r_rem  [0:N];
    logic [63:0]    r_nq   [0:N];
    logic [63:0]    r_d    [0:N];
    logic           r_neg  [0:N];
    logic           r_zero [0:N];
    psc_pkg::t_word r_quo;
    logic           r_zero_o;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= 64'd0;
            r_nq[0]   <= i_num[63] ? 64'd0 - i_num : i_num;
            r_d[0]    <= i_den[63] ? 64'd0 - i_den : i_den;
            r_neg[0]  <= i_num[63] ^ i_den[63];
            r_zero[0] <= (i_den == 64'd0);
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_iter
        logic [64:0] w_trial;
        logic [64:0] w_diff;
        logic        w_bit;

        assign w_trial = {r_rem[g], r_nq[g][63]};
        assign w_diff  = w_trial - {1'b0, r_d[g]};
        assign w_bit   = !w_diff[64];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= w_bit ? w_diff[63:0] : w_trial[63:0];
                r_nq[g+1]   <= {r_nq[g][62:0], w_bit};
                r_d[g+1]    <= r_d[g];
                r_neg[g+1]  <= r_neg[g];
                r_zero[g+1] <= r_zero[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo    <= r_neg[N] ? 64'd0 - r_nq[N] : r_nq[N];
            r_zero_o <= r_zero[N];
        end
    end

    assign o_quo  = r_quo;
    assign o_zero = r_zero_o;
endmodule

// ===== hw/rtl/pressure_sensor_compensation_core.sv =====
// Throughput: one word per cycle while the output is not stalled; the divider pipeline sets
// the latency. A stalled output freezes the whole pipeline; one input word is then held
// in a skid register. Reset (synchronous, active low) clears all valid bits, the skid
// valid flag and the calibration registers to zero.
module pressure_sensor_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_pressure,
    input  logic [20:0] i_temp_fine,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_zero_divisor,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [psc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int unsigned L = psc_pkg::Latency;

    // Calibration registers.
    logic [15:0] r_cal_p1, r_cal_p2, r_cal_p3, r_cal_p4, r_cal_p5, r_cal_p6, r_cal_p7;
    logic [31:0] r_cal_p8_p9;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_p1    <= 16'd0;
            r_cal_p2    <= 16'd0;
            r_cal_p3    <= 16'd0;
            r_cal_p4    <= 16'd0;
            r_cal_p5    <= 16'd0;
            r_cal_p6    <= 16'd0;
            r_cal_p7    <= 16'd0;
            r_cal_p8_p9 <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psc_pkg::CFG_CAL_P1:    r_cal_p1    <= i_cfg_data[15:0];
                psc_pkg::CFG_CAL_P2:    r_cal_p2    <= i_cfg_data[15:0];
                psc_pkg::CFG_CAL_P3:    r_cal_p3    <= i_cfg_data[15:0];
                psc_pkg::CFG_CAL_P4:    r_cal_p4    <= i_cfg_data[15:0];
                psc_pkg::CFG_CAL_P5:    r_cal_p5    <= i_cfg_data[15:0];
                psc_pkg::CFG_CAL_P6:    r_cal_p6    <= i_cfg_data[15:0];
                psc_pkg::CFG_CAL_P7:    r_cal_p7    <= i_cfg_data[15:0];
                psc_pkg::CFG_CAL_P8_P9: r_cal_p8_p9 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic        w_en;
    logic        r_vld [1:L];
    logic        r_skid_v;
    logic [19:0] r_skid_raw;
    logic [20:0] r_skid_tf;
    logic [19:0] w_src_raw;
    logic [20:0] w_src_tf;
    logic        w_src_v;

    assign w_en      = !(r_vld[L] && i_stall);
    assign o_stall   = r_skid_v;
    assign w_src_raw = r_skid_v ? r_skid_raw : i_raw_pressure;
    assign w_src_tf  = r_skid_v ? r_skid_tf : i_temp_fine;
    assign w_src_v   = r_skid_v || i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= L; k++) r_vld[k] <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld[1] <= w_src_v;
                for (int k = 2; k <= L; k++) r_vld[k] <= r_vld[k-1];
                r_skid_v <= 1'b0;
            end else if (i_valid && !r_skid_v) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && i_valid && !r_skid_v) begin
            r_skid_raw <= i_raw_pressure;
            r_skid_tf  <= i_temp_fine;
        end
    end

    // Signed coefficients.
    logic signed [15:0] w_p2, w_p3, w_p5, w_p6, w_p8, w_p9;
    assign w_p2 = $signed(r_cal_p2);
    assign w_p3 = $signed(r_cal_p3);
    assign w_p5 = $signed(r_cal_p5);
    assign w_p6 = $signed(r_cal_p6);
    assign w_p8 = $signed(r_cal_p8_p9[15:0]);
    assign w_p9 = $signed(r_cal_p8_p9[31:16]);

    // Stage 1: temperature offset.
    logic signed [21:0] r_a;
    logic signed [21:0] n_a;
    logic [19:0]        r_raw [1:5];
    assign n_a = $signed({w_src_tf[20], w_src_tf}) - psc_pkg::TEMP_OFFSET;

    // Stage 2: first products.
    logic signed [43:0] n_aa;
    logic signed [37:0] n_ap5, n_ap2;
    psc_pkg::t_word     r_aa;
    logic signed [37:0] r_ap5 [2:4];
    logic signed [37:0] r_ap2 [2:4];
    assign n_aa  = r_a * r_a;
    assign n_ap5 = r_a * w_p5;
    assign n_ap2 = r_a * w_p2;

    // Stages 3-4: quadratic terms.
    psc_pkg::t_word w_aap6, w_aap3;

    psc_mul64 u_mul_p6 (.i_clk(i_clk), .i_en(w_en), .i_x(r_aa),
                        .i_y({w_p6[15], w_p6}), .o_p(w_aap6));
    psc_mul64 u_mul_p3 (.i_clk(i_clk), .i_en(w_en), .i_x(r_aa),
                        .i_y({w_p3[15], w_p3}), .o_p(w_aap3));

    // Stage 5: offset and divisor sums.
    psc_pkg::t_word r_b, r_a2;
    // Stage 6: multiplier operands.
    psc_pkg::t_word r_x, r_num;
    // Stages 7-8: scaled products.
    psc_pkg::t_word w_m, w_n;

    psc_mul64 u_mul_p1 (.i_clk(i_clk), .i_en(w_en), .i_x(r_x),
                        .i_y($signed({1'b0, r_cal_p1})), .o_p(w_m));
    psc_mul64 u_mul_sc (.i_clk(i_clk), .i_en(w_en), .i_x(r_num),
                        .i_y(psc_pkg::SCALE_3125), .o_p(w_n));

    // Stage 9: divisor.
    psc_pkg::t_word r_div, r_n9;

    // Stages 10-75: division.
    psc_pkg::t_word w_p;
    logic           w_zd;

    psc_div u_div (.i_clk(i_clk), .i_en(w_en), .i_num(r_n9), .i_den(r_div),
                   .o_quo(w_p), .o_zero(w_zd));

    // Stage 76 onward: second-order correction.
    psc_pkg::t_word r_q;
    psc_pkg::t_word r_pd [76:81];
    logic           r_zd [76:82];
    psc_pkg::t_word w_qq, w_p8p, w_p9qq;
    psc_pkg::t_word r_p8p [79:80];
    psc_pkg::t_word r_a3, r_b3, r_s;
    logic [31:0]    r_out;
    logic           r_zflag;
    psc_pkg::t_word w_fin;

    psc_sq64  u_sq     (.i_clk(i_clk), .i_en(w_en), .i_x(r_q), .o_p(w_qq));
    psc_mul64 u_mul_p8 (.i_clk(i_clk), .i_en(w_en), .i_x(r_pd[76]),
                        .i_y({w_p8[15], w_p8}), .o_p(w_p8p));
    psc_mul64 u_mul_p9 (.i_clk(i_clk), .i_en(w_en), .i_x(w_qq),
                        .i_y({w_p9[15], w_p9}), .o_p(w_p9qq));

    assign w_fin = psc_pkg::f_sdiv_pow2(r_s, 8)
                 + {{44{r_cal_p7[15]}}, r_cal_p7, 4'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a      <= n_a;
            r_raw[1] <= w_src_raw;
            for (int k = 2; k <= 5; k++) r_raw[k] <= r_raw[k-1];

            r_aa     <= {{20{n_aa[43]}}, n_aa};
            r_ap5[2] <= n_ap5;
            r_ap2[2] <= n_ap2;
            for (int k = 3; k <= 4; k++) begin
                r_ap5[k] <= r_ap5[k-1];
                r_ap2[k] <= r_ap2[k-1];
            end

            r_b  <= w_aap6 + {{9{r_ap5[4][37]}}, r_ap5[4], 17'd0}
                  + {{13{r_cal_p4[15]}}, r_cal_p4, 35'd0};
            r_a2 <= psc_pkg::f_sdiv_pow2(w_aap3, 8)
                  + {{14{r_ap2[4][37]}}, r_ap2[4], 12'd0};

            r_x   <= r_a2 + psc_pkg::OFFSET_TERM;
            r_num <= ((psc_pkg::FULL_SCALE - {44'd0, r_raw[5]}) << 31) - r_b;

            r_div <= psc_pkg::f_sdiv_pow2(w_m, 33);
            r_n9  <= w_n;

            r_q      <= psc_pkg::f_sdiv_pow2(w_p, 13);
            r_pd[76] <= w_p;
            r_zd[76] <= w_zd;
            for (int k = 77; k <= 81; k++) r_pd[k] <= r_pd[k-1];
            for (int k = 77; k <= 82; k++) r_zd[k] <= r_zd[k-1];

            r_p8p[79] <= w_p8p;
            r_p8p[80] <= r_p8p[79];

            r_a3 <= psc_pkg::f_sdiv_pow2(w_p9qq, 25);
            r_b3 <= psc_pkg::f_sdiv_pow2(r_p8p[80], 19);
            r_s  <= r_pd[81] + r_a3 + r_b3;

            r_out   <= r_zd[82] ? 32'd0 : w_fin[31:0];
            r_zflag <= r_zd[82];
        end
    end

    assign o_valid          = r_vld[L];
    assign o_pressure_q24_8 = r_out;
    assign o_zero_divisor   = r_zflag;

    // A flagged result always carries zero pressure.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor |-> o_pressure_q24_8 == 32'd0)
        else $error("zero divisor result with nonzero pressure");

    // The skid register only fills while the pipeline is frozen.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_v ##1 r_skid_v |-> $past(!w_en))
        else $error("skid register filled while pipeline was moving");

    // A held word stays in the skid register until the pipeline moves.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !w_en |=> r_skid_v && $stable(r_skid_raw) && $stable(r_skid_tf))
        else $error("skid word lost during stall");

    // A result waiting on a stalled output is not dropped.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pressure_q24_8))
        else $error("stalled result changed");
endmodule
